// ----- rtl/sgl_pkg.sv -----
// ----------------------------------------------------------------------------
// sgl_pkg: shared types and constants of the sequence gap loss tracker
// Window word geometry, command codes, word unit operations and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package sgl_pkg;

  // window storage geometry
  localparam int WORD_BITS       = 64;
  localparam int WORD_LOG        = 6;
  localparam int WINDOW_BITS_DEF = 1024;

  // payload widths
  localparam int SEQ_W  = 32;
  localparam int DROP_W = 31;

  // item command codes
  typedef enum logic {
    CMD_ARRIVAL  = 1'b0,
    CMD_FINALIZE = 1'b1
  } cmd_t;

  // operations of the shared window word unit
  typedef enum logic [1:0] {
    WOP_SHIFT,
    WOP_MARK,
    WOP_RUN,
    WOP_TOP
  } wop_t;

  // word unit result: new word, a bit count or index, and a flag
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [WORD_LOG:0]    cnt;
    logic                 flag;
  } wu_res_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DECIDE,
    ST_RUN_SCAN,
    ST_SH_PRIME,
    ST_SH_LOAD,
    ST_SHIFT,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_TOP_SCAN,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/sgl_if.sv -----
// ----------------------------------------------------------------------------
// sgl_if: item channels of the sequence gap loss tracker
// Input channel (command, sequence number) and result channel (dropped
// count, watermark, pending flag), each with valid/ready.
// ----------------------------------------------------------------------------
interface sgl_in_if;
  import sgl_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [SEQ_W-1:0] seq_number;

  modport source (output valid, output command, output seq_number, input ready);
  modport sink   (input valid, input command, input seq_number, output ready);
endinterface

interface sgl_out_if;
  import sgl_pkg::*;

  logic              valid;
  logic              ready;
  logic [DROP_W-1:0] newly_dropped;
  logic [SEQ_W-1:0]  next_expected;
  logic              window_pending;

  modport source (output valid, output newly_dropped, output next_expected,
                  output window_pending, input ready);
  modport sink   (input valid, input newly_dropped, input next_expected,
                  input window_pending, output ready);
endinterface

// ----- rtl/sequence_gap_loss_tracker.sv -----
// ----------------------------------------------------------------------------
// sequence_gap_loss_tracker: sequence number gap and loss tracker
// Keeps a watermark and an arrival window of WINDOW_BITS positions and
// reports the numbers judged lost by each arrival or finalize item.
// ----------------------------------------------------------------------------
// One item is taken at a time; every item gives exactly one result. The
// window lives in a single-port-read memory of W = ceil(WINDOW_BITS/64)
// 64-bit words, and its sweeps set the cost of an item: an arrival that
// matches the watermark scans the run of marked successors (R words, R is
// 1 unless whole words are marked) and then rewrites the window shifted.
// An arrival ahead inside the window reads and rewrites one word, and a
// finalize scans the words down from the top to the highest marked bit.
// A result waits in an output register, so the next item is taken while
// it is still held. Window words carry valid bits, so reset and every
// window clear take effect at once, with no clearing pass.
// ----------------------------------------------------------------------------
module sequence_gap_loss_tracker #(
  parameter int WINDOW_BITS = sgl_pkg::WINDOW_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sgl_in_if.sink    in_ch,
  sgl_out_if.source out_ch
);
  import sgl_pkg::*;

  localparam int WORDS = (WINDOW_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RA_W  = $clog2(2 * WORDS + 2);
  localparam int CNT_W = $clog2(WINDOW_BITS + 1);
  localparam int POS_W = $clog2(WINDOW_BITS);
  localparam int SH_W  = $clog2(WINDOW_BITS + 2);

  state_t              state_r, state_nxt;
  logic                started_r, started_nxt;
  logic [SEQ_W-1:0]    exp_r, exp_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                cmd_r, cmd_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [SEQ_W-1:0]    diff_r, diff_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SH_W-1:0]     sh_r, sh_nxt;
  logic [SH_W-1:0]     run_r, run_nxt;
  logic [RA_W-1:0]     cur_r, cur_nxt;
  logic [WORD_BITS-1:0] lo_r, lo_nxt;
  logic [DROP_W-1:0]   drop_r, drop_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DROP_W-1:0]   out_drop_r, out_drop_nxt;
  logic [SEQ_W-1:0]    out_exp_r, out_exp_nxt;
  logic                out_pend_r, out_pend_nxt;

  logic [SH_W-1:0]      run_sum;
  logic [RA_W-1:0]      rd_ptr;
  logic [RA_W-1:0]      q_word;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 win_clear;
  wop_t                 wu_op;
  logic [WORD_BITS-1:0] wu_lo;
  logic [WORD_LOG-1:0]  wu_amt;
  wu_res_t              wu_res;

  // window memory
  sgl_win_ram #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (win_clear),
    .we          (ram_we),
    .waddr       (ram_waddr),
    .wdata       (wu_res.word),
    .raddr       (AW'(rd_ptr)),
    .rd_in_range (rd_ptr < RA_W'(WORDS)),
    .rdata       (ram_rdata)
  );

  // shared word unit
  sgl_word_unit u_wu (
    .op  (wu_op),
    .lo  (wu_lo),
    .hi  (ram_rdata),
    .amt (wu_amt),
    .res (wu_res)
  );

  // whole-word part of the shift amount
  assign q_word = RA_W'(sh_r >> WORD_LOG);

  // handshake and result ports
  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.newly_dropped  = out_drop_r;
  assign out_ch.next_expected  = out_exp_r;
  assign out_ch.window_pending = out_pend_r;

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    exp_nxt       = exp_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    seq_nxt       = seq_r;
    diff_nxt      = diff_r;
    pos_nxt       = pos_r;
    sh_nxt        = sh_r;
    run_nxt       = run_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_drop_nxt  = out_drop_r;
    out_exp_nxt   = out_exp_r;
    out_pend_nxt  = out_pend_r;
    run_sum       = run_r + SH_W'(wu_res.cnt);
    rd_ptr        = '0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    win_clear     = 1'b0;
    wu_op         = WOP_SHIFT;
    wu_lo         = ram_rdata;
    wu_amt        = WORD_LOG'(sh_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          seq_nxt   = in_ch.seq_number;
          state_nxt = ST_DIFF;
        end
      end

      // signed distance from the watermark
      ST_DIFF: begin
        diff_nxt  = seq_r - exp_r;
        drop_nxt  = '0;
        state_nxt = ST_DECIDE;
      end

      // classify the item
      ST_DECIDE: begin
        priority if (cmd_r == CMD_FINALIZE) begin
          if (cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            rd_ptr    = RA_W'(WORDS - 1);
            cur_nxt   = RA_W'(WORDS - 1);
            state_nxt = ST_TOP_SCAN;
          end
        end else if (!started_r) begin
          started_nxt = 1'b1;
          exp_nxt     = seq_r + SEQ_W'(1);
          state_nxt   = ST_DONE;
        end else if (diff_r == '0) begin
          rd_ptr    = '0;
          cur_nxt   = '0;
          run_nxt   = '0;
          state_nxt = ST_RUN_SCAN;
        end else if (diff_r[SEQ_W-1]) begin
          state_nxt = ST_DONE;
        end else if (diff_r <= SEQ_W'(WINDOW_BITS)) begin
          pos_nxt   = POS_W'(diff_r - SEQ_W'(1));
          state_nxt = ST_MARK_RD;
        end else begin
          drop_nxt  = DROP_W'(diff_r - SEQ_W'(cnt_r));
          win_clear = 1'b1;
          cnt_nxt   = '0;
          exp_nxt   = seq_r + SEQ_W'(1);
          state_nxt = ST_DONE;
        end
      end

      // length of the marked run right above the watermark
      ST_RUN_SCAN: begin
        wu_op  = WOP_RUN;
        rd_ptr = cur_r + RA_W'(1);
        if (wu_res.flag && (cur_r != RA_W'(WORDS - 1))) begin
          run_nxt = run_sum;
          cur_nxt = cur_r + RA_W'(1);
        end else begin
          sh_nxt    = run_sum + SH_W'(1);
          cnt_nxt   = cnt_r - CNT_W'(run_sum);
          state_nxt = ST_SH_PRIME;
        end
      end

      // advance the watermark, fetch the first source word
      ST_SH_PRIME: begin
        rd_ptr    = q_word;
        exp_nxt   = exp_r + SEQ_W'(sh_r);
        cur_nxt   = '0;
        state_nxt = ST_SH_LOAD;
      end

      ST_SH_LOAD: begin
        lo_nxt    = ram_rdata;
        rd_ptr    = q_word + RA_W'(1);
        state_nxt = ST_SHIFT;
      end

      // rewrite the window one word a cycle, shifted down
      ST_SHIFT: begin
        wu_op     = WOP_SHIFT;
        wu_lo     = lo_r;
        ram_we    = 1'b1;
        ram_waddr = AW'(cur_r);
        lo_nxt    = ram_rdata;
        rd_ptr    = q_word + cur_r + RA_W'(2);
        if (cur_r == RA_W'(WORDS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cur_nxt = cur_r + RA_W'(1);
        end
      end

      // mark an arrival ahead of the watermark
      ST_MARK_RD: begin
        rd_ptr    = RA_W'(pos_r >> WORD_LOG);
        state_nxt = ST_MARK_WR;
      end

      ST_MARK_WR: begin
        wu_op     = WOP_MARK;
        wu_amt    = WORD_LOG'(pos_r);
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_r >> WORD_LOG);
        if (!wu_res.flag) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        state_nxt = ST_DONE;
      end

      // finalize: find the highest marked bit, word by word from the top
      ST_TOP_SCAN: begin
        wu_op = WOP_TOP;
        if (wu_res.flag) begin
          drop_nxt  = (DROP_W'(cur_r) << WORD_LOG) + DROP_W'(wu_res.cnt)
                      + DROP_W'(2) - DROP_W'(cnt_r);
          win_clear = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cur_nxt = cur_r - RA_W'(1);
          rd_ptr  = cur_r - RA_W'(1);
        end
      end

      // hand the result to the output register
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_drop_nxt  = drop_r;
          out_exp_nxt   = exp_r;
          out_pend_nxt  = (cnt_r != '0);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      exp_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      exp_r       <= exp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    seq_r      <= seq_nxt;
    diff_r     <= diff_nxt;
    pos_r      <= pos_nxt;
    sh_r       <= sh_nxt;
    run_r      <= run_nxt;
    cur_r      <= cur_nxt;
    lo_r       <= lo_nxt;
    drop_r     <= drop_nxt;
    out_drop_r <= out_drop_nxt;
    out_exp_r  <= out_exp_nxt;
    out_pend_r <= out_pend_nxt;
  end

`ifndef SYNTHESIS
  // the set-bit count never exceeds the window size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW_BITS))
    else $error("window set-bit count out of range");

  // once started, the tracker stays started
  a_started_hold: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag dropped");

  // an accepted item goes straight to the distance step
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_DIFF))
    else $error("accepted item not processed");

  // a finished item reaches the output register when the slot is free
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && (!out_valid_r || out_ch.ready) |=> out_valid_r)
    else $error("finished item not presented");

  // a fresh result reports the current pending state of the window
  a_pend_match: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_pend_r == (cnt_r != '0)))
    else $error("pending flag does not match window");
`endif

endmodule

// ----- rtl/sgl_win_ram.sv -----
// ----------------------------------------------------------------------------
// sgl_win_ram: arrival window word memory
// One write port, one registered read port, and a valid bit per word so
// that the whole window clears at once. Words not valid read as zero.
// ----------------------------------------------------------------------------
module sgl_win_ram #(
  parameter int WORDS = 16,
  parameter int AW    = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [sgl_pkg::WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  input  logic                          rd_in_range,
  output logic [sgl_pkg::WORD_BITS-1:0] rdata
);
  import sgl_pkg::*;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     valid_r;
  logic [WORD_BITS-1:0] rd_word_r;
  logic                 rd_vld_r;

  // word storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_word_r <= mem[raddr];
  end

  // per-word valid bits, cleared at once
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rd_vld_r <= rd_in_range && valid_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_word_r : '0;

endmodule

// ----- rtl/sgl_word_unit.sv -----
// ----------------------------------------------------------------------------
// sgl_word_unit: shared window word unit
// Funnel shift of two words, bit marking, trailing-ones run length and
// highest set bit search on one 64-bit window word.
// ----------------------------------------------------------------------------
module sgl_word_unit (
  input  sgl_pkg::wop_t                 op,
  input  logic [sgl_pkg::WORD_BITS-1:0] lo,
  input  logic [sgl_pkg::WORD_BITS-1:0] hi,
  input  logic [sgl_pkg::WORD_LOG-1:0]  amt,
  output sgl_pkg::wu_res_t              res
);
  import sgl_pkg::*;

  logic [2*WORD_BITS-1:0] cat;
  logic [WORD_BITS-1:0]   inv;
  logic [WORD_BITS-1:0]   iso;
  logic [WORD_BITS-1:0]   rev;
  logic [WORD_BITS-1:0]   riso;
  logic [WORD_LOG-1:0]    iso_idx;
  logic [WORD_LOG-1:0]    riso_idx;

  // lowest clear bit and highest set bit, isolated and encoded
  always_comb begin
    cat = {hi, lo} >> amt;
    inv = ~lo;
    iso = inv & (~inv + WORD_BITS'(1));
    for (int i = 0; i < WORD_BITS; i++) begin
      rev[i] = lo[WORD_BITS-1-i];
    end
    riso = rev & (~rev + WORD_BITS'(1));
    iso_idx  = '0;
    riso_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        iso_idx = iso_idx | WORD_LOG'(i);
      end
      if (riso[i]) begin
        riso_idx = riso_idx | WORD_LOG'(i);
      end
    end
  end

  // operation select
  always_comb begin
    res = '0;
    unique case (op)
      WOP_SHIFT: begin
        res.word = cat[WORD_BITS-1:0];
      end
      WOP_MARK: begin
        res.word = lo | (WORD_BITS'(1) << amt);
        res.flag = lo[amt];
      end
      WOP_RUN: begin
        res.flag = (inv == '0);
        res.cnt  = (inv == '0) ? (WORD_LOG+1)'(WORD_BITS) : {1'b0, iso_idx};
      end
      WOP_TOP: begin
        res.flag = (lo != '0);
        res.cnt  = {1'b0, WORD_LOG'(WORD_BITS - 1) - riso_idx};
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule
